@@ sv/bmb_pkg.sv @@
// Shared types, codes and helpers for the bit matrix blit block.
// No dependencies; imported by bmb_cfg, bmb_ctrl and the top module.
`timescale 1ns / 1ps

package bmb_pkg;

    localparam int DEF_MAX_ROWS      = 256;
    localparam int DEF_MAX_ROW_BYTES = 32;

    // operation codes
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_FILL   = 3'd2;
    localparam logic [2:0] OP_INVERT = 3'd3;
    localparam logic [2:0] OP_AND    = 3'd4;
    localparam logic [2:0] OP_OR     = 3'd5;

    // register indexes
    localparam logic [2:0] REG_DEST_WIDTH  = 3'd0;
    localparam logic [2:0] REG_DEST_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SRC_WIDTH   = 3'd2;
    localparam logic [2:0] REG_OFFSET_X    = 3'd3;
    localparam logic [2:0] REG_OFFSET_Y    = 3'd4;

    localparam logic [8:0] RST_DEST_WIDTH  = 9'd256;
    localparam logic [8:0] RST_DEST_HEIGHT = 9'd256;
    localparam logic [8:0] RST_SRC_WIDTH   = 9'd256;

    // effective configuration, saturated and decoded
    typedef struct packed {
        logic [8:0] dw;        // destination width in bits
        logic [8:0] dh;        // destination rows
        logic [8:0] sw;        // source width in bits
        logic [6:0] nb;        // destination bytes per row
        logic [6:0] sb;        // source bytes
        logic [7:0] ox;
        logic [7:0] oy;
        logic [7:0] last_mask; // valid bits of the last byte of a row
    } cfg_t;

    // ones in bits 0..bit_mask
    function automatic logic [7:0] tail_mask(input logic [2:0] bit_mask);
        logic [8:0] t;
        t = (9'd1 << (4'(bit_mask) + 4'd1)) - 9'd1;
        return t[7:0];
    endfunction

endpackage

@@ sv/bmb_store.sv @@
// Byte store: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module bmb_store #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/bmb_cfg.sv @@
// APB register file for the blit geometry and its decoded effective values.
// Depends on bmb_pkg.
`timescale 1ns / 1ps

module bmb_cfg
    import bmb_pkg::*;
#(
    parameter int MAX_ROWS      = DEF_MAX_ROWS,
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [8:0] dest_width_reg, dest_height_reg, src_width_reg;
    logic [7:0] offset_x_reg, offset_y_reg;
    logic       wr_en;
    logic [8:0] dw0, dh0;
    logic [8:0] dw, dh, sw;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_width_reg  <= RST_DEST_WIDTH;
            dest_height_reg <= RST_DEST_HEIGHT;
            src_width_reg   <= RST_SRC_WIDTH;
            offset_x_reg    <= 8'd0;
            offset_y_reg    <= 8'd0;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_DEST_WIDTH:  dest_width_reg  <= pwdata[8:0];
                REG_DEST_HEIGHT: dest_height_reg <= pwdata[8:0];
                REG_SRC_WIDTH:   src_width_reg   <= pwdata[8:0];
                REG_OFFSET_X:    offset_x_reg    <= pwdata[7:0];
                REG_OFFSET_Y:    offset_y_reg    <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_DEST_WIDTH:  prdata = 32'(dest_width_reg);
            REG_DEST_HEIGHT: prdata = 32'(dest_height_reg);
            REG_SRC_WIDTH:   prdata = 32'(src_width_reg);
            REG_OFFSET_X:    prdata = 32'(offset_x_reg);
            REG_OFFSET_Y:    prdata = 32'(offset_y_reg);
            default:         prdata = 32'd0;
        endcase
    end

    // zero acts as one; clip to the store geometry
    assign dw0 = (dest_width_reg == 9'd0) ? 9'd1 : dest_width_reg;
    assign dh0 = (dest_height_reg == 9'd0) ? 9'd1 : dest_height_reg;
    assign sw  = (src_width_reg == 9'd0) ? 9'd1 : src_width_reg;
    assign dw  = (32'(dw0) > 8 * MAX_ROW_BYTES) ? 9'(8 * MAX_ROW_BYTES) : dw0;
    assign dh  = (32'(dh0) > MAX_ROWS) ? 9'(MAX_ROWS) : dh0;

    always_comb
    begin
        cfg.dw        = dw;
        cfg.dh        = dh;
        cfg.sw        = sw;
        cfg.nb        = 7'((10'(dw) + 10'd7) >> 3);
        cfg.sb        = 7'((10'(sw) + 10'd7) >> 3);
        cfg.ox        = offset_x_reg;
        cfg.oy        = offset_y_reg;
        cfg.last_mask = tail_mask(3'(dw - 9'd1));
    end

endmodule

@@ sv/bmb_ctrl.sv @@
// Operation sequencer: decode, read-modify-write of the store, fill/invert
// sweep, and the result register with one skid entry. Depends on bmb_pkg.
`timescale 1ns / 1ps

module bmb_ctrl
    import bmb_pkg::*;
#(
    parameter int MAX_ROWS      = DEF_MAX_ROWS,
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
    parameter int AW            = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    operation,
    input  logic [7:0]    row,
    input  logic [4:0]    column,
    input  logic [7:0]    data_byte,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    read_data,
    output logic          position_error,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic          mem_re,
    output logic [AW-1:0] mem_raddr,
    input  logic [7:0]    mem_rdata
);

    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_AO1   = 3'd2;
    localparam logic [2:0] ST_AO2   = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;

    function automatic logic [AW-1:0] addr_of(input logic [RIW-1:0] r,
                                              input logic [CIW-1:0] c);
        return AW'(32'(r) * MAX_ROW_BYTES + 32'(c));
    endfunction

    logic [2:0]     state_reg, state_next;
    logic [RIW-1:0] y_reg, y_next;
    logic [CIW-1:0] x_reg, x_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [7:0]     lo_reg, lo_next, hi_reg, hi_next;
    logic           is_and_reg, is_and_next;
    logic           is_fill_reg, is_fill_next;
    logic           hi_ok_reg, hi_ok_next;
    logic           inv_v_reg, inv_v_next;

    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_data_reg, out_data_next;
    logic           out_err_reg, out_err_next;
    logic           pend_valid_reg, pend_valid_next;
    logic [7:0]     pend_data_reg, pend_data_next;
    logic           pend_err_reg, pend_err_next;

    logic           accept;
    logic           res_push;
    logic [7:0]     res_data;
    logic           res_err;

    // decode of the incoming item
    logic           rw_err, ao_err, hi_ok;
    logic [8:0]     drow, left;
    logic [5:0]     dcol;
    logic [7:0]     smask, and_src, or_src;
    logic [15:0]    and_v, or_v;
    logic [AW-1:0]  rw_addr, ao_addr, sweep_addr;
    logic           x_last, y_last;
    logic [7:0]     comb_src, comb_byte;

    assign in_ready = (state_reg == ST_IDLE) && !pend_valid_reg;
    assign accept   = in_valid && in_ready;

    assign rw_err = (9'(row) >= cfg.dh) || (7'(column) >= cfg.nb);
    assign drow   = 9'(row) + 9'(cfg.oy);
    assign ao_err = (7'(column) >= cfg.sb) || (drow >= cfg.dh)
                    || ((10'(cfg.ox) + 10'(cfg.sw)) > 10'(cfg.dw));
    assign left   = cfg.sw - 9'({column, 3'b000});
    assign smask  = (left >= 9'd8) ? 8'hFF : tail_mask(3'(left[2:0] - 3'd1));
    assign and_src = data_byte | ~smask;
    assign or_src  = data_byte & smask;
    // AND keeps ones outside the placed bits
    assign and_v  = (16'(and_src) << cfg.ox[2:0]) | ~(16'h00FF << cfg.ox[2:0]);
    assign or_v   = 16'(or_src) << cfg.ox[2:0];
    assign dcol   = 6'(cfg.ox[7:3]) + 6'(column);
    assign hi_ok  = (7'(dcol) + 7'd1) < cfg.nb;

    assign rw_addr    = addr_of(RIW'(row), CIW'(column));
    assign ao_addr    = addr_of(RIW'(drow), CIW'(dcol));
    assign sweep_addr = addr_of(y_reg, x_reg);
    assign x_last     = (32'(x_reg) + 1) == 32'(cfg.nb);
    assign y_last     = (32'(y_reg) + 1) == 32'(cfg.dh);

    assign comb_src  = (state_reg == ST_AO2) ? hi_reg : lo_reg;
    assign comb_byte = is_and_reg ? (mem_rdata & comb_src) : (mem_rdata | comb_src);

    always_comb
    begin
        state_next   = state_reg;
        y_next       = y_reg;
        x_next       = x_reg;
        addr_next    = addr_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        is_and_next  = is_and_reg;
        is_fill_next = is_fill_reg;
        hi_ok_next   = hi_ok_reg;
        inv_v_next   = inv_v_reg;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg;
        mem_wdata    = comb_byte;
        mem_re       = 1'b0;
        mem_raddr    = addr_reg;
        res_push     = 1'b0;
        res_data     = 8'd0;
        res_err      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next       = '0;
                    y_next       = '0;
                    inv_v_next   = 1'b0;
                    is_and_next  = (operation == OP_AND);
                    is_fill_next = (operation == OP_FILL);
                    case (operation)
                        OP_WRITE:
                        begin
                            res_push = 1'b1;
                            res_err  = rw_err;
                            if (!rw_err)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = rw_addr;
                                mem_wdata = data_byte;
                            end
                        end
                        OP_READ:
                        begin
                            if (rw_err)
                            begin
                                res_push = 1'b1;
                                res_err  = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = rw_addr;
                                state_next = ST_RD;
                            end
                        end
                        OP_FILL, OP_INVERT:
                        begin
                            state_next = ST_SWEEP;
                        end
                        OP_AND, OP_OR:
                        begin
                            if (ao_err)
                            begin
                                res_push = 1'b1;
                                res_err  = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = ao_addr;
                                addr_next  = ao_addr;
                                lo_next    = (operation == OP_AND) ? and_v[7:0] : or_v[7:0];
                                hi_next    = (operation == OP_AND) ? and_v[15:8] : or_v[15:8];
                                hi_ok_next = hi_ok;
                                state_next = ST_AO1;
                            end
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                res_push   = 1'b1;
                res_data   = mem_rdata;
                state_next = ST_IDLE;
            end
            ST_AO1:
            begin
                mem_we = 1'b1;
                if (hi_ok_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = addr_reg + AW'(1);
                    addr_next  = addr_reg + AW'(1);
                    state_next = ST_AO2;
                end
                else
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_AO2:
            begin
                mem_we     = 1'b1;
                res_push   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (is_fill_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = sweep_addr;
                    mem_wdata = x_last ? cfg.last_mask : 8'hFF;
                end
                else
                begin
                    // read this byte, write back the one read last cycle
                    mem_re     = 1'b1;
                    mem_raddr  = sweep_addr;
                    mem_we     = inv_v_reg;
                    mem_wdata  = ~mem_rdata;
                    inv_v_next = 1'b1;
                    addr_next  = sweep_addr;
                end
                if (x_last)
                begin
                    x_next = '0;
                    if (y_last)
                    begin
                        if (is_fill_reg)
                        begin
                            res_push   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                    else
                    begin
                        y_next = y_reg + RIW'(1);
                    end
                end
                else
                begin
                    x_next = x_reg + CIW'(1);
                end
            end
            ST_DRAIN:
            begin
                mem_we     = 1'b1;
                mem_wdata  = ~mem_rdata;
                inv_v_next = 1'b0;
                res_push   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register plus one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_err_next    = out_err_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        pend_err_next   = pend_err_reg;
        if (out_valid_reg && !out_ready)
        begin
            if (res_push)
            begin
                pend_valid_next = 1'b1;
                pend_data_next  = res_data;
                pend_err_next   = res_err;
            end
        end
        else if (pend_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = pend_data_reg;
            out_err_next    = pend_err_reg;
            pend_valid_next = res_push;
            pend_data_next  = res_data;
            pend_err_next   = res_err;
        end
        else
        begin
            out_valid_next = res_push;
            out_data_next  = res_data;
            out_err_next   = res_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            inv_v_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            inv_v_reg      <= inv_v_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg         <= y_next;
        x_reg         <= x_next;
        addr_reg      <= addr_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        is_and_reg    <= is_and_next;
        is_fill_reg   <= is_fill_next;
        hi_ok_reg     <= hi_ok_next;
        out_data_reg  <= out_data_next;
        out_err_reg   <= out_err_next;
        pend_data_reg <= pend_data_next;
        pend_err_reg  <= pend_err_next;
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = out_data_reg;
    assign position_error = out_err_reg;

    a_push_skid_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !pend_valid_reg)
        else $error("result produced while skid entry is occupied");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item while output register is empty");

    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == ST_IDLE) |-> (accept && operation == OP_WRITE))
        else $error("store written in idle without an accepted write item");

    a_drain_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> inv_v_reg)
        else $error("invert drain without a pending write-back");

endmodule

@@ sv/bit_matrix_blit_and_or.sv @@
// Bit matrix blit with AND/OR raster ops on a packed byte store.
// Write, error and unused codes give their result on accept; read goes through
// ST_RD; and/or read-modify-write one or two bytes (ST_AO1, then ST_AO2) on the
// store's single write port; fill and invert sweep dh*nb bytes, invert via ST_DRAIN.
// One item at a time; a new item is taken while one result waits, not while two do.
// Reset: asynchronous active low, registers to defaults; store contents undefined.
`timescale 1ns / 1ps

module bit_matrix_blit_and_or
    import bmb_pkg::*;
#(
    parameter int MAX_ROWS      = DEF_MAX_ROWS,
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [7:0]  row,
    input  logic [4:0]  column,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        position_error
);

    localparam int DEPTH = MAX_ROWS * MAX_ROW_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfg_t          cfg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    bmb_cfg #(
        .MAX_ROWS      (MAX_ROWS),
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bmb_ctrl #(
        .MAX_ROWS      (MAX_ROWS),
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .AW            (AW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .row            (row),
        .column         (column),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .position_error (position_error),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

    bmb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
